@@ src/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// shared types, constants and the month length decode for the calendar clock
// ----------------------------------------------------------------------------
package cct_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int TICK_OUT_WIDTH = 32;

   localparam logic [6:0] SECS_LIMIT  = 7'd60;
   localparam logic [6:0] MINS_LIMIT  = 7'd60;
   localparam logic [5:0] HOURS_LIMIT = 6'd24;
   localparam logic [4:0] MONTH_LIMIT = 5'd13;

   typedef enum logic [2:0] {
      EV_SECOND = 3'd0,
      EV_MINUTE = 3'd1,
      EV_MIN10  = 3'd2,
      EV_MIN15  = 3'd3,
      EV_MIN30  = 3'd4,
      EV_HOUR   = 3'd5,
      EV_DAY    = 3'd6,
      EV_LOADED = 3'd7
   } event_type;

   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hours;
      logic [5:0] mins;
      logic [5:0] secs;
   } time_type;

   typedef struct packed {
      event_type               ev;
      time_type                tod;
      logic [COUNT_WIDTH-1:0]  count;
   } result_type;

   localparam logic [3:0] MONTH_FEB = 4'd2;

   // days in month; out-of-range month code 13 gives 30 days, codes 0, 14 and 15 give 31
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic [7:0] year);
      logic [4:0] days;
      unique case (month) inside
         MONTH_FEB:                           days = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11, 4'd13:      days = 5'd30;
         default:                             days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

@@ src/cct_step.sv @@
// ----------------------------------------------------------------------------
// cct_step
// next date and time and event class for one load or one-second advance
// ----------------------------------------------------------------------------
module cct_step
   import cct_pkg::*;
(
   input  logic      func,
   input  time_type  load_tod,
   input  time_type  cur_tod,
   output time_type  next_tod,
   output event_type next_ev
);

   logic [6:0] sec_sum;
   logic       sec_carry;
   logic [6:0] min_sum;
   logic       min_carry;
   logic [5:0] hr_sum;
   logic       hr_carry;
   logic [5:0] day_sum;
   logic       day_carry;
   logic [4:0] mon_sum;
   logic       mon_carry;
   logic [4:0] dim;
   event_type  min_ev;
   time_type   tick_tod;
   event_type  tick_ev;

   always_comb begin
      dim       = month_days(cur_tod.month, cur_tod.year);
      sec_sum   = {1'b0, cur_tod.secs} + 7'd1;
      sec_carry = (sec_sum >= SECS_LIMIT);
      min_sum   = {1'b0, cur_tod.mins} + {6'd0, sec_carry};
      min_carry = (min_sum >= MINS_LIMIT);
      hr_sum    = {1'b0, cur_tod.hours} + {5'd0, min_carry};
      hr_carry  = (hr_sum >= HOURS_LIMIT);
      day_sum   = {1'b0, cur_tod.day} + {5'd0, hr_carry};
      day_carry = (day_sum > {1'b0, dim});
      mon_sum   = {1'b0, cur_tod.month} + {4'd0, day_carry};
      mon_carry = (mon_sum >= MONTH_LIMIT);

      // minute marks
      case (min_sum) inside
         7'd30:                       min_ev = EV_MIN30;
         7'd15, 7'd45:                min_ev = EV_MIN15;
         7'd10, 7'd20, 7'd40, 7'd50:  min_ev = EV_MIN10;
         default:                     min_ev = EV_MINUTE;
      endcase

      tick_tod.secs  = sec_carry ? 6'd0 : sec_sum[5:0];
      tick_tod.mins  = min_carry ? 6'd0 : min_sum[5:0];
      tick_tod.hours = hr_carry  ? 5'd0 : hr_sum[4:0];
      tick_tod.day   = day_carry ? 5'd1 : day_sum[4:0];
      tick_tod.month = mon_carry ? 4'd1 : mon_sum[3:0];
      tick_tod.year  = cur_tod.year + {7'd0, mon_carry};

      if (hr_carry || day_carry) begin
         tick_ev = EV_DAY;
      end else if (min_carry) begin
         tick_ev = EV_HOUR;
      end else if (sec_carry) begin
         tick_ev = min_ev;
      end else begin
         tick_ev = EV_SECOND;
      end

      next_tod = func ? load_tod  : tick_tod;
      next_ev  = func ? EV_LOADED : tick_ev;
   end

endmodule

@@ src/cct_out_reg.sv @@
// ----------------------------------------------------------------------------
// cct_out_reg
// result register, refilled in the cycle it is drained
// ----------------------------------------------------------------------------
module cct_out_reg
   import cct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       busy,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign busy      = valid_ff && rsp_stall;
   assign valid_in  = load || busy;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

@@ src/calendar_clock_tick_core.sv @@
// ----------------------------------------------------------------------------
// calendar_clock_tick_core
// real-time clock calendar: one-second advance or date/time load per transaction
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | func, new date and time
//   rsp_     | out       | rsp_valid/rsp_stall  | event class, date, time, tick count
//
// one transaction per cycle while the result is not stalled, result valid in the cycle after acceptance
// throughput set by the single result register, refilled as it drains
// reset: 2000-01-01 00:00:00, tick count zero, no result pending
// a stalled result holds req_stall high until it is taken
// ----------------------------------------------------------------------------
module calendar_clock_tick_core
   import cct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_new_year,
   input  logic [3:0]  req_new_month,
   input  logic [4:0]  req_new_day,
   input  logic [4:0]  req_new_hours,
   input  logic [5:0]  req_new_mins,
   input  logic [5:0]  req_new_secs,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hours,
   output logic [5:0]  rsp_mins,
   output logic [5:0]  rsp_secs,
   output logic [31:0] rsp_tick_count
);

   time_type               tod_ff;
   time_type               tod_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   time_type               load_tod;
   event_type              next_ev;
   logic                   accept;
   logic                   busy;
   result_type             result_in;
   result_type             result;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   assign load_tod.year  = req_new_year;
   assign load_tod.month = req_new_month;
   assign load_tod.day   = req_new_day;
   assign load_tod.hours = req_new_hours;
   assign load_tod.mins  = req_new_mins;
   assign load_tod.secs  = req_new_secs;

   cct_step u_step (
      .func     (req_func),
      .load_tod (load_tod),
      .cur_tod  (tod_ff),
      .next_tod (tod_in),
      .next_ev  (next_ev)
   );

   assign count_in = req_func ? count_ff : count_ff + COUNT_WIDTH'(1);

   assign result_in.ev    = next_ev;
   assign result_in.tod   = tod_in;
   assign result_in.count = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tod_ff.year  <= 8'd0;
         tod_ff.month <= 4'd1;
         tod_ff.day   <= 5'd1;
         tod_ff.hours <= 5'd0;
         tod_ff.mins  <= 6'd0;
         tod_ff.secs  <= 6'd0;
         count_ff     <= '0;
      end else if (accept) begin
         tod_ff   <= tod_in;
         count_ff <= count_in;
      end
   end

   cct_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (result_in),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (result)
   );

   assign rsp_event_res  = result.ev;
   assign rsp_year       = result.tod.year;
   assign rsp_month      = result.tod.month;
   assign rsp_day        = result.tod.day;
   assign rsp_hours      = result.tod.hours;
   assign rsp_mins       = result.tod.mins;
   assign rsp_secs       = result.tod.secs;
   assign rsp_tick_count = TICK_OUT_WIDTH'(result.count);

endmodule
